FILE: sv/tdf_pkg.sv
// Shared types, character codes and register indexes for the text display filter.
package tdf_pkg;

    // Default width of the line number field, in decimal digits
    localparam int NUMBER_DIGITS_DEF = 6;
    // Entries in the queue between classifier and expander
    localparam int QUEUE_DEPTH_DEF = 2;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_QUEST  = 8'd63;
    localparam logic [7:0] CH_AT     = 8'd64;
    localparam logic [7:0] CH_I      = 8'd73;
    localparam logic [7:0] CH_M      = 8'd77;
    localparam logic [7:0] CH_CARET  = 8'd94;
    localparam logic [6:0] CH_DEL    = 7'd127;
    localparam logic [6:0] CH_CTL_END = 7'd32;

    // Configuration register indexes
    localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd0;
    localparam logic [2:0] REG_NUMBER_ALL       = 3'd1;
    localparam logic [2:0] REG_NUMBER_NONBLANK  = 3'd2;
    localparam logic [2:0] REG_SHOW_ENDS        = 3'd3;
    localparam logic [2:0] REG_SHOW_TABS        = 3'd4;
    localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd5;

    typedef struct packed {
        logic squeeze_blank;
        logic number_all;
        logic number_nonblank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    // Classified item: number prefix flag plus the 1 to 4 character bytes
    typedef struct packed {
        logic            numbered;
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } t_tail;

endpackage

FILE: sv/tdf_front.sv
// Classifier: keeps the stream state, squeezes blank lines, counts lines, builds escapes.
module tdf_front #(
    parameter int NUMBER_DIGITS = tdf_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tdf_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_byte,
    input  logic                         i_file_start,
    input  logic                         i_full,
    output logic                         o_push,
    output tdf_pkg::t_tail               o_tail,
    output logic [4*NUMBER_DIGITS-1:0]   o_bcd,
    output logic [NUMBER_DIGITS-1:0]     o_shown
);
    import tdf_pkg::*;

    localparam int BW = 4 * NUMBER_DIGITS;

    logic [7:0]    r_prev, n_prev;
    logic [1:0]    r_run, n_run;
    logic [BW-1:0] r_bcd, n_bcd;

    logic [7:0]    prev_eff;
    logic [1:0]    run_eff;
    logic [BW-1:0] bcd_eff, bcd_inc;
    logic          is_nl, prev_nl, squeezed, numbered, accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && !squeezed;

    // Line state: file start clears it before the byte is looked at
    always_comb begin
        logic       all9;
        logic       carry;
        logic [3:0] d;
        prev_eff = i_file_start ? CH_NL : r_prev;
        run_eff  = i_file_start ? 2'd0 : r_run;
        bcd_eff  = i_file_start ? '0 : r_bcd;
        is_nl    = (i_byte == CH_NL);
        prev_nl  = (prev_eff == CH_NL);

        if (is_nl && prev_nl) begin
            n_run = (run_eff == 2'd3) ? 2'd3 : run_eff + 2'd1;
        end else begin
            n_run = 2'd0;
        end
        squeezed = i_cfg.squeeze_blank && (n_run > 2'd1);

        if (i_cfg.number_nonblank) begin
            numbered = prev_nl && !is_nl && !squeezed;
        end else begin
            numbered = i_cfg.number_all && prev_nl && !squeezed;
        end

        // BCD increment, held at all nines
        all9  = 1'b1;
        carry = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            d = bcd_eff[4*i +: 4];
            if (d != 4'd9) begin
                all9 = 1'b0;
            end
            if (carry) begin
                bcd_inc[4*i +: 4] = (d == 4'd9) ? 4'd0 : d + 4'd1;
            end else begin
                bcd_inc[4*i +: 4] = d;
            end
            carry = carry && (d == 4'd9);
        end
        if (numbered && !all9) begin
            n_bcd = bcd_inc;
        end else begin
            n_bcd = bcd_eff;
        end
        n_prev = i_byte;
    end

    // Leading zeros of the number field print as spaces
    always_comb begin
        logic any;
        any = 1'b0;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            any = any || (n_bcd[4*i +: 4] != 4'd0);
            o_shown[i] = any || (i == 0);
        end
    end
    assign o_bcd = n_bcd;

    // Character part: tab, newline, escaped byte or plain byte
    always_comb begin
        logic [2:0] n;
        logic [6:0] lo;
        logic       ctl;
        n  = 3'd0;
        lo = i_byte[6:0];
        ctl = (lo < CH_CTL_END) || (lo == CH_DEL);
        o_tail.numbered = numbered;
        o_tail.bytes    = '0;
        if (i_byte == CH_TAB) begin
            if (i_cfg.show_tabs) begin
                o_tail.bytes[0] = CH_CARET;
                o_tail.bytes[1] = CH_I;
                n = 3'd2;
            end else begin
                o_tail.bytes[0] = CH_TAB;
                n = 3'd1;
            end
        end else if (is_nl) begin
            if (i_cfg.show_ends) begin
                o_tail.bytes[0] = CH_DOLLAR;
                o_tail.bytes[1] = CH_NL;
                n = 3'd2;
            end else begin
                o_tail.bytes[0] = CH_NL;
                n = 3'd1;
            end
        end else if (i_cfg.show_nonprinting) begin
            if (i_byte[7]) begin
                o_tail.bytes[0] = CH_M;
                o_tail.bytes[1] = CH_MINUS;
                n = 3'd2;
            end
            if (ctl) begin
                o_tail.bytes[n[1:0]] = CH_CARET;
                n = n + 3'd1;
                o_tail.bytes[n[1:0]] = (lo == CH_DEL) ? CH_QUEST : {1'b0, lo} + CH_AT;
            end else begin
                o_tail.bytes[n[1:0]] = {1'b0, lo};
            end
            n = n + 3'd1;
        end else begin
            o_tail.bytes[0] = i_byte;
            n = 3'd1;
        end
        o_tail.len = n;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= CH_NL;
            r_run  <= 2'd0;
            r_bcd  <= '0;
        end else if (accept) begin
            r_prev <= n_prev;
            r_run  <= n_run;
            r_bcd  <= n_bcd;
        end
    end

endmodule

FILE: sv/tdf_fifo.sv
// Small register queue between classifier and expander.
module tdf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tdf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_data  = r_mem[r_rd];

    // Pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

endmodule

FILE: sv/tdf_back.sv
// Expander: walks the head item byte by byte into the registered output stage.
module tdf_back #(
    parameter int NUMBER_DIGITS = tdf_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  tdf_pkg::t_tail               i_tail,
    input  logic [4*NUMBER_DIGITS-1:0]   i_bcd,
    input  logic [NUMBER_DIGITS-1:0]     i_shown,
    output logic                         o_pop,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [7:0]                   o_tdata,
    output logic                         o_tlast
);
    import tdf_pkg::*;

    // Wide enough to hold the beat count of the longest item
    localparam int PW = $clog2(NUMBER_DIGITS + 6);

    logic [PW-1:0] r_pos, n_pos;
    logic          r_ovalid;
    logic [7:0]    r_odata, n_byte;
    logic          r_olast;
    logic [PW-1:0] total, tpos;
    logic          last, load;

    assign total = i_tail.numbered ? PW'(NUMBER_DIGITS + 1) + PW'(i_tail.len)
                                   : PW'(i_tail.len);
    assign last  = (r_pos == total - PW'(1));
    assign load  = i_valid && (!r_ovalid || i_tready);
    assign o_pop = load && last;
    assign tpos  = r_pos - (i_tail.numbered ? PW'(NUMBER_DIGITS + 1) : PW'(0));

    // Byte at the current position: digits, tab, then character bytes
    always_comb begin
        n_byte = i_tail.bytes[tpos[1:0]];
        if (i_tail.numbered) begin
            if (r_pos == PW'(NUMBER_DIGITS)) begin
                n_byte = CH_TAB;
            end
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
                if (r_pos == PW'(NUMBER_DIGITS - 1 - i)) begin
                    n_byte = i_shown[i] ? CH_ZERO + {4'd0, i_bcd[4*i +: 4]} : CH_SPACE;
                end
            end
        end
    end

    assign n_pos = last ? '0 : r_pos + PW'(1);

    // Position counter and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_pos    <= n_pos;
            r_ovalid <= 1'b1;
        end else if (i_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_odata <= n_byte;
            r_olast <= last;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (r_pos < total))
        else $error("expander position past end of item");
    a_pos_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |-> (r_pos == '0))
        else $error("expander position nonzero with no item");
    a_last_marks_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_olast == $past(o_pop)))
        else $error("tlast does not match item end");

endmodule

FILE: sv/text_display_filter.sv
// Top level of the text display filter: config registers, classifier, queue, expander.
//
// Each accepted byte yields 1 to NUMBER_DIGITS+5 output beats (none for a squeezed
// blank line). The output side sends one beat per cycle while the sink is ready, so
// plain bytes stream at one per cycle unless the output stalls. The classifier
// takes a new byte every cycle while the two-entry queue has room, so input and
// output stall independently. Configuration is meant to change only while idle.
module text_display_filter #(
    parameter int NUMBER_DIGITS = tdf_pkg::NUMBER_DIGITS_DEF,
    parameter int QUEUE_DEPTH   = tdf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tuser,   // [0] file_start
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic       i_cfg_wdata
);
    import tdf_pkg::*;

    localparam int BW = 4 * NUMBER_DIGITS;
    localparam int QW = $bits(t_tail) + BW + NUMBER_DIGITS;

    t_cfg                   r_cfg;
    t_tail                  f_tail, b_tail;
    logic [BW-1:0]          f_bcd, b_bcd;
    logic [NUMBER_DIGITS-1:0] f_shown, b_shown;
    logic                   push, pop, q_valid, q_full;
    logic [QW-1:0]          q_head;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_wdata;
                REG_NUMBER_ALL:       r_cfg.number_all       <= i_cfg_wdata;
                REG_NUMBER_NONBLANK:  r_cfg.number_nonblank  <= i_cfg_wdata;
                REG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_wdata;
                REG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_wdata;
                REG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    tdf_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_byte       (i_s_tdata),
        .i_file_start (i_s_tuser),
        .i_full       (q_full),
        .o_push       (push),
        .o_tail       (f_tail),
        .o_bcd        (f_bcd),
        .o_shown      (f_shown)
    );

    tdf_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_tail, f_bcd, f_shown}),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_head)
    );

    assign {b_tail, b_bcd, b_shown} = q_head;

    tdf_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_tail   (b_tail),
        .i_bcd    (b_bcd),
        .i_shown  (b_shown),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

endmodule
